>>> rtl/core/qsl_pkg.sv
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;
    localparam int RANGE_W   = 2 * IDX_W;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     last_item;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflowed;
    } result_t;

endpackage

>>> rtl/core/quicksort_lomuto.sv
`timescale 1ns / 1ps

// In-place quicksort over a set of signed 32-bit values.
// Sample channel: one request per value (sample_valid / sample_stall / sample).
// Requests are written into the element store one per cycle; a request with
// last_item set closes the set and starts the sort. Requests beyond the store
// capacity are dropped, and every result of that run carries overflowed.
// While sorting and emitting, sample_stall stays high.
// Result channel: one request per stored value in ascending order
// (result_valid / result_stall / result), last_out on the final one.
// Sorting uses Lomuto partitioning with the last element of each range as
// pivot and a stack memory of pending ranges. A swapped element costs more
// than one that stays in place, since the store has a single read and a
// single write port. Each result is read from the store and then loaded into
// the output register before the next one is read. The output register holds
// a result while result_stall is high; emission pauses behind it. Once the
// final result is loaded, a new set may begin. Reset (rst_n low, asynchronous)
// empties the store, clears the overflow mark and drops any result not yet
// taken.
module quicksort_lomuto (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  qsl_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output qsl_pkg::result_t result
);
    import qsl_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_RANGE = 4'd3;
    localparam logic [3:0] S_PIV   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_SWAP1 = 4'd6;
    localparam logic [3:0] S_SWAP2 = 4'd7;
    localparam logic [3:0] S_FIN1  = 4'd8;
    localparam logic [3:0] S_FIN2  = 4'd9;
    localparam logic [3:0] S_FIN3  = 4'd10;
    localparam logic [3:0] S_PUSH1 = 4'd11;
    localparam logic [3:0] S_PUSH2 = 4'd12;
    localparam logic [3:0] S_ERD   = 4'd13;
    localparam logic [3:0] S_EWR   = 4'd14;

    // Element store and range stack: one write and one registered read each.
    logic signed [DATA_W-1:0] store_mem [MAX_ITEMS];
    logic [RANGE_W-1:0]       stack_mem [MAX_ITEMS];

    logic                     st_we;
    logic [IDX_W-1:0]         st_waddr;
    logic signed [DATA_W-1:0] st_wdata;
    logic                     st_re;
    logic [IDX_W-1:0]         st_raddr;
    logic signed [DATA_W-1:0] st_rdata_reg;

    logic                     stk_we;
    logic [IDX_W-1:0]         stk_waddr;
    logic [RANGE_W-1:0]       stk_wdata;
    logic                     stk_re;
    logic [IDX_W-1:0]         stk_raddr;
    logic [RANGE_W-1:0]       stk_rdata_reg;

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;

    // Sequencer payload.
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         j_reg, j_next;
    logic [IDX_W-1:0]         nx_reg, nx_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] aj_reg, aj_next;
    result_t                  out_reg, out_next;

    // Derived compare terms.
    logic [IDX_W:0]   j_inc;
    logic [IDX_W:0]   nx_inc;
    logic [IDX_W:0]   lo_inc;
    logic             j_more;
    logic             elem_le;
    logic [IDX_W-1:0] top_idx;
    logic             emit_last;
    logic             stack_room;
    logic             out_free;

    assign j_inc      = {1'b0, j_reg} + (IDX_W+1)'(1);
    assign nx_inc     = {1'b0, nx_reg} + (IDX_W+1)'(1);
    assign lo_inc     = {1'b0, lo_reg} + (IDX_W+1)'(1);
    assign j_more     = j_inc < {1'b0, hi_reg};
    assign elem_le    = st_rdata_reg <= pivot_reg;
    assign top_idx    = IDX_W'(count_reg - CNT_W'(1));
    assign emit_last  = (k_reg == top_idx);
    assign stack_room = (sp_reg < CNT_W'(MAX_ITEMS));
    assign out_free   = !out_valid_reg || !result_stall;

    assign sample_stall = (state_reg != S_LOAD);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rdata_reg <= store_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        nx_next        = nx_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        aj_next        = aj_reg;
        out_next       = out_reg;

        st_we     = 1'b0;
        st_waddr  = '0;
        st_wdata  = '0;
        st_re     = 1'b0;
        st_raddr  = '0;
        stk_we    = 1'b0;
        stk_waddr = sp_reg[IDX_W-1:0];
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;

        // Drop the held result once the receiver takes it.
        if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (sample_valid)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        st_we      = 1'b1;
                        st_waddr   = count_reg[IDX_W-1:0];
                        st_wdata   = sample.sample_value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (sample.last_item)
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            S_INIT:
            begin
                k_next = '0;
                if (count_reg < CNT_W'(2))
                begin
                    state_next = S_ERD;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = {IDX_W'(0), top_idx};
                    sp_next    = sp_reg + CNT_W'(1);
                    state_next = S_POP;
                end
            end

            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    stk_re     = 1'b1;
                    stk_raddr  = IDX_W'(sp_reg - CNT_W'(1));
                    sp_next    = sp_reg - CNT_W'(1);
                    state_next = S_RANGE;
                end
            end

            S_RANGE:
            begin
                lo_next = stk_rdata_reg[RANGE_W-1:IDX_W];
                hi_next = stk_rdata_reg[IDX_W-1:0];
                j_next  = stk_rdata_reg[RANGE_W-1:IDX_W];
                nx_next = stk_rdata_reg[RANGE_W-1:IDX_W];
                if (stk_rdata_reg[RANGE_W-1:IDX_W] >= stk_rdata_reg[IDX_W-1:0])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = stk_rdata_reg[IDX_W-1:0];
                    state_next = S_PIV;
                end
            end

            S_PIV:
            begin
                pivot_next = st_rdata_reg;
                st_re      = 1'b1;
                st_raddr   = j_reg;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (elem_le && (nx_reg != j_reg))
                begin
                    // Fetch the first large element to trade places with.
                    aj_next    = st_rdata_reg;
                    st_re      = 1'b1;
                    st_raddr   = nx_reg;
                    state_next = S_SWAP1;
                end
                else
                begin
                    if (elem_le)
                    begin
                        nx_next = nx_inc[IDX_W-1:0];
                    end
                    j_next = j_inc[IDX_W-1:0];
                    if (j_more)
                    begin
                        st_re    = 1'b1;
                        st_raddr = j_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        state_next = S_FIN1;
                    end
                end
            end

            S_SWAP1:
            begin
                st_we      = 1'b1;
                st_waddr   = nx_reg;
                st_wdata   = aj_reg;
                state_next = S_SWAP2;
            end

            S_SWAP2:
            begin
                st_we    = 1'b1;
                st_waddr = j_reg;
                st_wdata = st_rdata_reg;
                nx_next  = nx_inc[IDX_W-1:0];
                j_next   = j_inc[IDX_W-1:0];
                if (j_more)
                begin
                    st_re      = 1'b1;
                    st_raddr   = j_inc[IDX_W-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_FIN1;
                end
            end

            S_FIN1:
            begin
                if (nx_reg == hi_reg)
                begin
                    state_next = S_PUSH1;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = nx_reg;
                    state_next = S_FIN2;
                end
            end

            S_FIN2:
            begin
                st_we      = 1'b1;
                st_waddr   = hi_reg;
                st_wdata   = st_rdata_reg;
                state_next = S_FIN3;
            end

            S_FIN3:
            begin
                // Drop the pivot into its final slot.
                st_we      = 1'b1;
                st_waddr   = nx_reg;
                st_wdata   = pivot_reg;
                state_next = S_PUSH1;
            end

            S_PUSH1:
            begin
                if ((nx_inc < {1'b0, hi_reg}) && stack_room)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {nx_inc[IDX_W-1:0], hi_reg};
                    sp_next   = sp_reg + CNT_W'(1);
                end
                state_next = S_PUSH2;
            end

            S_PUSH2:
            begin
                if (({1'b0, nx_reg} > lo_inc) && stack_room)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, nx_reg - IDX_W'(1)};
                    sp_next   = sp_reg + CNT_W'(1);
                end
                state_next = S_POP;
            end

            S_ERD:
            begin
                st_re      = 1'b1;
                st_raddr   = k_reg;
                state_next = S_EWR;
            end

            S_EWR:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.sorted_value = st_rdata_reg;
                    out_next.last_out     = emit_last;
                    out_next.overflowed   = ovf_reg;
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_ERD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        j_reg     <= j_next;
        nx_reg    <= nx_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        aj_reg    <= aj_next;
        out_reg   <= out_next;
    end

endmodule
